// ----- hdl/wbct_pkg.sv -----
// shared constants, codes and types for the work/break countdown timer
package wbct_pkg;

    // field widths
    localparam int MODE_W   = 4;
    localparam int SEC_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // default count width
    localparam int COUNT_BITS_DEF = 16;

    // register reset values
    localparam logic [SEC_W-1:0] WORK_RESET  = 16'd1500;
    localparam logic [SEC_W-1:0] BREAK_RESET = 16'd300;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 1'd1;

    // event modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ADD    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SUB    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BRK_ON = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BRK_OFF = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 4'd8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PLAY_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BRK_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NEG_ERR  = 2'd3;

    // timer control flags
    typedef struct packed {
        logic break_phase;
        logic is_playing;
        logic was_idle;
    } flags_t;

    // per-beat report
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                break_started;
        logic                break_ended;
    } report_t;

endpackage

// ----- hdl/wbct_ifs.sv -----
// valid/ready channel interfaces for timer events and results

// event channel
interface wbct_in_if;
    logic                         valid;
    logic                         ready;
    logic [wbct_pkg::MODE_W-1:0]  mode;
    logic [wbct_pkg::SEC_W-1:0]   amount_seconds;
    logic                         user_idle;

    modport source (output valid, output mode, output amount_seconds, output user_idle,
                    input ready);
    modport sink   (input valid, input mode, input amount_seconds, input user_idle,
                    output ready);
endinterface

// result channel
interface wbct_out_if;
    logic                           valid;
    logic                           ready;
    logic [wbct_pkg::SEC_W-1:0]     remaining_seconds;
    logic                           on_break;
    logic                           running;
    logic [wbct_pkg::STATUS_W-1:0]  status;
    logic                           break_started;
    logic                           break_ended;

    modport source (output valid, output remaining_seconds, output on_break, output running,
                    output status, output break_started, output break_ended,
                    input ready);
    modport sink   (input valid, input remaining_seconds, input on_break, input running,
                    input status, input break_started, input break_ended,
                    output ready);
endinterface

// ----- hdl/wbct_cfg.sv -----
// phase length registers with write port
module wbct_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wbct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbct_pkg::SEC_W-1:0]       cfg_data,
    output logic [wbct_pkg::SEC_W-1:0]       work_len,
    output logic [wbct_pkg::SEC_W-1:0]       break_len
);

    logic [wbct_pkg::SEC_W-1:0] work_reg;
    logic [wbct_pkg::SEC_W-1:0] break_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg  <= wbct_pkg::WORK_RESET;
            break_reg <= wbct_pkg::BREAK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wbct_pkg::CFG_WORK)
                work_reg <= cfg_data;
            if (cfg_index == wbct_pkg::CFG_BREAK)
                break_reg <= cfg_data;
        end
    end

    assign work_len  = work_reg;
    assign break_len = break_reg;

endmodule

// ----- hdl/wbct_step.sv -----
// next-state logic for one timer event
module wbct_step
#(
    parameter int COUNT_BITS = wbct_pkg::COUNT_BITS_DEF
)
(
    input  logic [COUNT_BITS-1:0]            count,
    input  wbct_pkg::flags_t                 flags,
    input  logic [wbct_pkg::SEC_W-1:0]       work_len,
    input  logic [wbct_pkg::SEC_W-1:0]       break_len,
    input  logic [wbct_pkg::MODE_W-1:0]      mode,
    input  logic [wbct_pkg::SEC_W-1:0]       amount,
    input  logic                             idle,
    output logic [COUNT_BITS-1:0]            count_next,
    output wbct_pkg::flags_t                 flags_next,
    output wbct_pkg::report_t                report
);

    // working width wide enough for count, lengths and a carry
    localparam int WIDE = ((COUNT_BITS > wbct_pkg::SEC_W) ? COUNT_BITS : wbct_pkg::SEC_W) + 1;
    localparam logic [WIDE-1:0] CMAX = WIDE'((64'd1 << COUNT_BITS) - 64'd1);

    logic [WIDE-1:0]       count_w;
    logic [WIDE-1:0]       amount_w;
    logic [WIDE-1:0]       work_w;
    logic [WIDE-1:0]       break_w;
    logic [WIDE-1:0]       sum_w;
    logic [WIDE-1:0]       diff_w;
    logic [COUNT_BITS-1:0] work_fit;
    logic [COUNT_BITS-1:0] break_fit;
    logic [COUNT_BITS-1:0] sum_fit;
    logic [COUNT_BITS-1:0] cnt_mid;
    logic                  chk_zero;
    logic                  brk_mid;

    // extended operands
    assign count_w  = WIDE'(count);
    assign amount_w = WIDE'(amount);
    assign work_w   = WIDE'(work_len);
    assign break_w  = WIDE'(break_len);
    assign sum_w    = count_w + amount_w;
    assign diff_w   = count_w - amount_w;

    // saturate loaded lengths and sums at the count range
    assign work_fit  = (work_w  > CMAX) ? CMAX[COUNT_BITS-1:0] : work_w[COUNT_BITS-1:0];
    assign break_fit = (break_w > CMAX) ? CMAX[COUNT_BITS-1:0] : break_w[COUNT_BITS-1:0];
    assign sum_fit   = (sum_w   > CMAX) ? CMAX[COUNT_BITS-1:0] : sum_w[COUNT_BITS-1:0];

    // event decode and phase flip on zero
    always_comb
    begin
        cnt_mid              = count;
        chk_zero             = 1'b0;
        flags_next           = flags;
        report.status        = wbct_pkg::ST_OK;
        report.break_started = 1'b0;
        report.break_ended   = 1'b0;

        unique case (mode)
            wbct_pkg::MODE_TICK:
            begin
                if (!idle)
                begin
                    if (flags.is_playing)
                    begin
                        if (count != '0)
                            cnt_mid = count - COUNT_BITS'(1);
                        chk_zero = 1'b1;
                    end
                    else
                        report.status = wbct_pkg::ST_PLAY_ERR;
                    flags_next.was_idle = 1'b0;
                end
                else if (!flags.was_idle)
                begin
                    cnt_mid             = work_fit;
                    chk_zero            = 1'b1;
                    flags_next.was_idle = 1'b1;
                end
            end
            wbct_pkg::MODE_PLAY:
            begin
                if (flags.is_playing)
                    report.status = wbct_pkg::ST_PLAY_ERR;
                else
                    flags_next.is_playing = 1'b1;
            end
            wbct_pkg::MODE_PAUSE:
            begin
                if (!flags.is_playing)
                    report.status = wbct_pkg::ST_PLAY_ERR;
                else
                    flags_next.is_playing = 1'b0;
            end
            wbct_pkg::MODE_TOGGLE:
            begin
                flags_next.is_playing = !flags.is_playing;
            end
            wbct_pkg::MODE_ADD:
            begin
                cnt_mid  = sum_fit;
                chk_zero = 1'b1;
            end
            wbct_pkg::MODE_SUB:
            begin
                if (amount_w > count_w)
                    report.status = wbct_pkg::ST_NEG_ERR;
                else
                begin
                    cnt_mid  = diff_w[COUNT_BITS-1:0];
                    chk_zero = 1'b1;
                end
            end
            wbct_pkg::MODE_BRK_ON:
            begin
                if (flags.break_phase)
                    report.status = wbct_pkg::ST_BRK_ERR;
                else
                begin
                    flags_next.break_phase = 1'b1;
                    cnt_mid                = break_fit;
                    report.break_started   = 1'b1;
                end
            end
            wbct_pkg::MODE_BRK_OFF:
            begin
                if (!flags.break_phase)
                    report.status = wbct_pkg::ST_BRK_ERR;
                else
                begin
                    flags_next.break_phase = 1'b0;
                    cnt_mid                = work_fit;
                    report.break_ended     = 1'b1;
                end
            end
            wbct_pkg::MODE_RELOAD:
            begin
                cnt_mid = work_fit;
            end
            default:
            begin
                cnt_mid = count;
            end
        endcase

        // single phase flip when a count change lands on zero
        brk_mid    = flags_next.break_phase;
        count_next = cnt_mid;
        if (chk_zero && (cnt_mid == '0))
        begin
            if (brk_mid)
            begin
                flags_next.break_phase = 1'b0;
                count_next             = work_fit;
                report.break_ended     = 1'b1;
            end
            else
            begin
                flags_next.break_phase = 1'b1;
                count_next             = break_fit;
                report.break_started   = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/work_break_countdown_timer.sv -----
// work/break countdown timer: one event beat in, one result beat out
// an accepted event beat is held in the input register until the output register can take it,
//   and its result is then loaded into the output register
// throughput: one beat per cycle while the result channel does not stall the output register
// reset: count loads the work length reset value, work phase, playing, not idle;
//   both length registers take their reset values and both pipeline stages empty
module work_break_countdown_timer
#(
    parameter int COUNT_BITS = wbct_pkg::COUNT_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    wbct_in_if.sink                          in,
    wbct_out_if.source                       out,
    input  logic                             cfg_we,
    input  logic [wbct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbct_pkg::SEC_W-1:0]       cfg_data
);

    localparam logic [63:0] CMAX64  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] WORK64  = 64'(wbct_pkg::WORK_RESET);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET =
        COUNT_BITS'((WORK64 > CMAX64) ? CMAX64 : WORK64);
    localparam int WIDE = ((COUNT_BITS > wbct_pkg::SEC_W) ? COUNT_BITS : wbct_pkg::SEC_W);

    logic [wbct_pkg::SEC_W-1:0]    work_len;
    logic [wbct_pkg::SEC_W-1:0]    break_len;

    // input stage
    logic                          in_valid_reg;
    logic [wbct_pkg::MODE_W-1:0]   mode_reg;
    logic [wbct_pkg::SEC_W-1:0]    amount_reg;
    logic                          idle_reg;

    // timer state
    logic [COUNT_BITS-1:0]         count_reg;
    logic [COUNT_BITS-1:0]         count_next;
    wbct_pkg::flags_t              flags_reg;
    wbct_pkg::flags_t              flags_next;
    wbct_pkg::report_t             report;

    // output stage
    logic                          out_valid_reg;
    logic [wbct_pkg::SEC_W-1:0]    remain_reg;
    logic                          on_break_reg;
    logic                          running_reg;
    wbct_pkg::report_t             report_reg;

    logic                          out_load;
    logic                          advance;
    logic [WIDE-1:0]               count_ext;

    wbct_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .work_len  (work_len),
        .break_len (break_len)
    );

    wbct_step #(.COUNT_BITS(COUNT_BITS)) u_step
    (
        .count      (count_reg),
        .flags      (flags_reg),
        .work_len   (work_len),
        .break_len  (break_len),
        .mode       (mode_reg),
        .amount     (amount_reg),
        .idle       (idle_reg),
        .count_next (count_next),
        .flags_next (flags_next),
        .report     (report)
    );

    // handshake between stages
    assign out_load = !out_valid_reg || out.ready;
    assign advance  = in_valid_reg && out_load;
    assign in.ready = !in_valid_reg || out_load;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in.ready)
            in_valid_reg <= in.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
        begin
            mode_reg   <= in.mode;
            amount_reg <= in.amount_seconds;
            idle_reg   <= in.user_idle;
        end
    end

    // timer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg             <= COUNT_RESET;
            flags_reg.break_phase <= 1'b0;
            flags_reg.is_playing  <= 1'b1;
            flags_reg.was_idle    <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    // low seconds bits of the new count
    assign count_ext = WIDE'(count_next);

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            remain_reg   <= count_ext[wbct_pkg::SEC_W-1:0];
            on_break_reg <= flags_next.break_phase;
            running_reg  <= flags_next.is_playing;
            report_reg   <= report;
        end
    end

    assign out.valid             = out_valid_reg;
    assign out.remaining_seconds = remain_reg;
    assign out.on_break          = on_break_reg;
    assign out.running           = running_reg;
    assign out.status            = report_reg.status;
    assign out.break_started     = report_reg.break_started;
    assign out.break_ended       = report_reg.break_ended;

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the work/break countdown timer
module tb;
    import wbct_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int CNT_W          = COUNT_BITS_DEF;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
    localparam int RANDOM_PHASES  = 5;
    localparam int BEATS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int SCRIPT_ROWS    = 25;

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEC_W-1:0]  amount;
        logic              idle;
    } event_t;

    typedef struct packed {
        logic [SEC_W-1:0]    remaining;
        logic                on_break;
        logic                running;
        logic [STATUS_W-1:0] status;
        logic                started;
        logic                ended;
    } result_t;

    typedef struct packed {
        event_t  ev;
        logic    typed;
        result_t want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SEC_W-1:0]     cfg_data;

    wbct_in_if  evt_ch ();
    wbct_out_if res_ch ();

    work_break_countdown_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (evt_ch),
        .out       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #(HALF_PERIOD) clk = ~clk;

    // timer state as the testbench sees it
    logic [CNT_W-1:0] tm_count;
    logic             tm_on_break;
    logic             tm_playing;
    logic             tm_was_idle;
    logic [SEC_W-1:0] len_work;
    logic [SEC_W-1:0] len_break;

    result_t     expected_results[$];
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned events_sent     = 0;
    int unsigned settings_run    = 0;
    int unsigned breaks_begun    = 0;
    int unsigned breaks_over     = 0;
    int unsigned cycle_count     = 0;
    bit          quiet           = 1'b0;

    // directed events; typed rows carry the expected beat worked out by hand
    script_row_t script [SCRIPT_ROWS] = '{
        '{'{MODE_TICK,    16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_PLAY,    16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b1, ST_PLAY_ERR, 1'b0, 1'b0}},
        '{'{MODE_PAUSE,   16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b0, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_PAUSE,   16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b0, ST_PLAY_ERR, 1'b0, 1'b0}},
        '{'{MODE_TICK,    16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b0, ST_PLAY_ERR, 1'b0, 1'b0}},
        '{'{MODE_TICK,    16'd0,     1'b1}, 1'b1, '{16'd1500,  1'b0, 1'b0, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_PLAY,    16'd0,     1'b0}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_BRK_OFF, 16'd0,     1'b0}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_BRK_ERR,  1'b0, 1'b0}},
        '{'{MODE_SUB,     16'd1501,  1'b0}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_NEG_ERR,  1'b0, 1'b0}},
        '{'{MODE_SUB,     16'd1500,  1'b0}, 1'b1, '{16'd300,   1'b1, 1'b1, ST_OK,       1'b1, 1'b0}},
        '{'{MODE_BRK_ON,  16'd0,     1'b0}, 1'b1, '{16'd300,   1'b1, 1'b1, ST_BRK_ERR,  1'b0, 1'b0}},
        '{'{MODE_ADD,     16'hFFFF,  1'b0}, 1'b1, '{16'hFFFF,  1'b1, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_ADD,     16'd0,     1'b0}, 1'b1, '{16'hFFFF,  1'b1, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_SUB,     16'hFFFF,  1'b0}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b1}},
        '{'{MODE_TICK,    16'd0,     1'b1}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_TICK,    16'd0,     1'b0}, 1'b1, '{16'd1499,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_TICK,    16'd0,     1'b1}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_TICK,    16'd0,     1'b1}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_BRK_ON,  16'd0,     1'b0}, 1'b1, '{16'd300,   1'b1, 1'b1, ST_OK,       1'b1, 1'b0}},
        '{'{MODE_RELOAD,  16'd0,     1'b0}, 1'b1, '{16'd1500,  1'b1, 1'b1, ST_OK,       1'b0, 1'b0}},
        '{'{MODE_BRK_OFF, 16'd0,     1'b0}, 1'b1, '{16'd1500,  1'b0, 1'b1, ST_OK,       1'b0, 1'b1}},
        '{'{MODE_SPARE_LO, 16'hAAAA, 1'b1}, 1'b0, '0},
        '{'{MODE_SPARE_HI, 16'h5555, 1'b0}, 1'b0, '0},
        '{'{MODE_SUB,     16'd0,     1'b0}, 1'b0, '0},
        '{'{MODE_TOGGLE,  16'd0,     1'b0}, 1'b0, '0}
    };

    // load a length into the count, saturating at the count's range
    function automatic logic [CNT_W-1:0] clamp_count(input longint unsigned v);
        return (v > CNT_MAX) ? CNT_W'(CNT_MAX) : v[CNT_W-1:0];
    endfunction

    // flip the phase once when the count has run down to zero
    function automatic void flip_on_zero(inout result_t r);
        if (tm_count != '0)
            return;
        if (tm_on_break)
        begin
            tm_on_break = 1'b0;
            tm_count    = clamp_count(len_work);
            r.ended     = 1'b1;
        end
        else
        begin
            tm_on_break = 1'b1;
            tm_count    = clamp_count(len_break);
            r.started   = 1'b1;
        end
    endfunction

    // apply one event to the timer state and return the result beat it causes
    function automatic result_t advance_timer(input event_t ev);
        result_t r;
        r = '0;
        r.status = ST_OK;
        case (ev.mode)
            MODE_TICK:
            begin
                if (!ev.idle)
                begin
                    if (tm_playing)
                    begin
                        if (tm_count != '0)
                            tm_count = tm_count - 1'b1;
                        flip_on_zero(r);
                    end
                    else
                        r.status = ST_PLAY_ERR;
                    tm_was_idle = 1'b0;
                end
                else if (!tm_was_idle)
                begin
                    tm_count = clamp_count(len_work);
                    flip_on_zero(r);
                    tm_was_idle = 1'b1;
                end
            end
            MODE_PLAY:
            begin
                if (tm_playing)
                    r.status = ST_PLAY_ERR;
                else
                    tm_playing = 1'b1;
            end
            MODE_PAUSE:
            begin
                if (!tm_playing)
                    r.status = ST_PLAY_ERR;
                else
                    tm_playing = 1'b0;
            end
            MODE_TOGGLE: tm_playing = ~tm_playing;
            MODE_ADD:
            begin
                tm_count = clamp_count(longint'(tm_count) + longint'(ev.amount));
                flip_on_zero(r);
            end
            MODE_SUB:
            begin
                if (longint'(ev.amount) > longint'(tm_count))
                    r.status = ST_NEG_ERR;
                else
                begin
                    tm_count = tm_count - CNT_W'(ev.amount);
                    flip_on_zero(r);
                end
            end
            MODE_BRK_ON:
            begin
                if (tm_on_break)
                    r.status = ST_BRK_ERR;
                else
                begin
                    tm_on_break = 1'b1;
                    tm_count    = clamp_count(len_break);
                    r.started   = 1'b1;
                end
            end
            MODE_BRK_OFF:
            begin
                if (!tm_on_break)
                    r.status = ST_BRK_ERR;
                else
                begin
                    tm_on_break = 1'b0;
                    tm_count    = clamp_count(len_work);
                    r.ended     = 1'b1;
                end
            end
            MODE_RELOAD: tm_count = clamp_count(len_work);
            default: ;
        endcase
        r.remaining = tm_count[SEC_W-1:0];
        r.on_break  = tm_on_break;
        r.running   = tm_playing;
        return r;
    endfunction

    // amounts lean towards the extremes and small values
    function automatic logic [SEC_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return SEC_W'($urandom_range(1, 12));
            default: return SEC_W'($urandom);
        endcase
    endfunction

    // random event, mostly ticks, with subtracts aimed at the current count
    function automatic event_t random_event();
        event_t      ev;
        int unsigned pick;
        pick      = $urandom_range(0, 99);
        ev.amount = SEC_W'($urandom);
        ev.idle   = 1'($urandom);
        if (pick < 35)
        begin
            ev.mode = MODE_TICK;
            ev.idle = 1'b0;
        end
        else if (pick < 45)
        begin
            ev.mode = MODE_TICK;
            ev.idle = 1'b1;
        end
        else if (pick < 50)
            ev.mode = MODE_PLAY;
        else if (pick < 55)
            ev.mode = MODE_PAUSE;
        else if (pick < 60)
            ev.mode = MODE_TOGGLE;
        else if (pick < 68)
        begin
            ev.mode   = MODE_ADD;
            ev.amount = pick_amount();
        end
        else if (pick < 78)
        begin
            ev.mode = MODE_SUB;
            case ($urandom_range(0, 2))
                0:       ev.amount = tm_count[SEC_W-1:0];
                1:       ev.amount = SEC_W'($urandom_range(0, int'(tm_count)));
                default: ev.amount = pick_amount();
            endcase
        end
        else if (pick < 83)
            ev.mode = MODE_BRK_ON;
        else if (pick < 88)
            ev.mode = MODE_BRK_OFF;
        else if (pick < 92)
            ev.mode = MODE_RELOAD;
        else
            ev.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return ev;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at result beat %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    // field by field comparison of one result beat
    task automatic compare_beat(input result_t got, input result_t want);
        if (got.remaining !== want.remaining)
            report_mismatch("remaining_seconds", got.remaining, want.remaining);
        if (got.on_break !== want.on_break)
            report_mismatch("on_break", got.on_break, want.on_break);
        if (got.running !== want.running)
            report_mismatch("running", got.running, want.running);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.started !== want.started)
            report_mismatch("break_started", got.started, want.started);
        if (got.ended !== want.ended)
            report_mismatch("break_ended", got.ended, want.ended);
    endtask

    // drive one event beat, with an optional gap first, and predict on acceptance
    task automatic put_event(input event_t ev, input logic typed, input result_t want);
        result_t     model;
        int unsigned gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 17);
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid          <= 1'b1;
        evt_ch.mode           <= ev.mode;
        evt_ch.amount_seconds <= ev.amount;
        evt_ch.user_idle      <= ev.idle;
        do
            @(posedge clk);
        while (evt_ch.ready !== 1'b1);
        model = advance_timer(ev);
        expected_results.push_back(typed ? want : model);
        events_sent++;
    endtask

    // wait for every result, then let the pipeline go quiet
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both phase lengths on consecutive edges
    task automatic set_lengths(input logic [SEC_W-1:0] work, input logic [SEC_W-1:0] brk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WORK;
        cfg_data  <= work;
        @(posedge clk);
        len_work   = work;
        cfg_index <= CFG_BREAK;
        cfg_data  <= brk;
        @(posedge clk);
        len_break  = brk;
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = '{res_ch.remaining_seconds, res_ch.on_break, res_ch.running,
                    res_ch.status, res_ch.break_started, res_ch.break_ended};
            if (expected_results.size() == 0)
                report_mismatch("result beat with nothing pending", got.remaining, 0);
            else
            begin
                want = expected_results.pop_front();
                compare_beat(got, want);
            end
            if (got.started === 1'b1)
                breaks_begun++;
            if (got.ended === 1'b1)
                breaks_over++;
            results_checked++;
        end
    end

    // result stalls in bursts, with runs of free flow between them
    int unsigned stall_left = 0;
    int unsigned flow_left  = 0;
    always @(posedge clk)
    begin
        if (quiet || rst_n !== 1'b1)
            res_ch.ready <= 1'b1;
        else if (stall_left != 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (flow_left != 0)
        begin
            res_ch.ready <= 1'b1;
            flow_left = flow_left - 1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
        begin
            res_ch.ready <= 1'b1;
            flow_left = $urandom_range(1, 40);
        end
    end

    // cycle count and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("run stopped at the cycle limit with %0d results pending",
                 expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [SEC_W-1:0] work;
        logic [SEC_W-1:0] brk;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_WORK;
        cfg_data              <= '0;
        evt_ch.valid          <= 1'b0;
        evt_ch.mode           <= MODE_TICK;
        evt_ch.amount_seconds <= '0;
        evt_ch.user_idle      <= 1'b0;

        // state after reset
        len_work    = WORK_RESET;
        len_break   = BREAK_RESET;
        tm_count    = clamp_count(WORK_RESET);
        tm_on_break = 1'b0;
        tm_playing  = 1'b1;
        tm_was_idle = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events at the reset lengths
        settings_run = 1;
        for (int i = 0; i < SCRIPT_ROWS; i++)
            put_event(script[i].ev, script[i].typed, script[i].want);
        evt_ch.valid <= 1'b0;

        // random events under a series of length settings, extremes first
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    work = 16'd1;
                    brk  = 16'd1;
                end
                1:
                begin
                    work = 16'hFFFF;
                    brk  = 16'hFFFF;
                end
                2:
                begin
                    work = 16'hFFFF;
                    brk  = 16'd1;
                end
                3:
                begin
                    work = SEC_W'($urandom_range(1, 8));
                    brk  = SEC_W'($urandom_range(1, 8));
                end
                default:
                begin
                    work = SEC_W'($urandom_range(2, 40));
                    brk  = SEC_W'($urandom_range(1, 20));
                end
            endcase
            set_lengths(work, brk);
            quiet = (p == RANDOM_PHASES - 1);
            repeat (BEATS_PER_PHASE)
                put_event(random_event(), 1'b0, '0);
            evt_ch.valid <= 1'b0;
        end

        // drain and account for anything never delivered
        wait_drained();
        while (expected_results.size() != 0)
        begin
            report_mismatch("missing result beat", 0, expected_results[0].remaining);
            void'(expected_results.pop_front());
        end

        $display("checked %0d result beats from %0d events under %0d length settings",
                 results_checked, events_sent, settings_run);
        $display("phase changes seen: %0d breaks begun, %0d breaks ended",
                 breaks_begun, breaks_over);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/wbct_pkg.sv
hdl/wbct_ifs.sv
hdl/wbct_cfg.sv
hdl/wbct_step.sv
hdl/work_break_countdown_timer.sv
tb/sv/tb.sv
